@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; imported by every module of the converter.
package hsv2rgb_pkg;

	// Default hue resolution: hue is hue_frac / 2^HUE_BITS of a full turn
	localparam int HUE_BITS_DEF = 16;

	// Full-scale saturation and value level
	localparam logic [7:0] LVL_MAX = 8'd255;

	// One pixel request in HSV form
	typedef struct packed {
		logic [15:0] hue_frac;
		logic [7:0]  sat_level;
		logic [7:0]  val_level;
	} hsv_pix_t;

	// One converted pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_pix_t;

	// Hue sector, named by the hue range it spans
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} hsv_sector_t;

	// Load enables of the four inner pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} hsv_stg_en_t;

	// floor(x / 255) for x up to 255*255: reciprocal estimate, then one correction
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		logic [8:0]  est;
		logic [16:0] prod;
		logic [16:0] rem;
		logic [8:0]  quo;
		sum  = {1'b0, x} + {9'd0, x[15:8]};
		est  = sum[16:8];
		prod = {est, 8'd0} - {8'd0, est};
		rem  = {1'b0, x} - prod;
		quo  = (rem >= 17'd255) ? est + 9'd1 : est;
		return quo[7:0];
	endfunction

endpackage

@@ hw/rtl/hsv_to_rgb_converter_unit.sv @@
// HSV to RGB converter, top level: stage valid tracking, stall control and
// output sector select. Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_scale.
// Each request passes through stages 1 to 4 and the stage 5 output register before rgb_valid.
// Throughput: one pixel per cycle; stalls ripple back only through full stages.
// Reset clears the stage valid bits; data registers are not reset.
module hsv_to_rgb_converter_unit
	import hsv2rgb_pkg::*;
#(
	parameter int HUE_BITS = HUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  hsv_pix_t  pix,
	output logic      rgb_valid,
	input  logic      rgb_ready,
	output rgb_pix_t  rgb
);

	hsv_stg_en_t         stg_en;
	logic                en_s5;
	logic [4:0]          vld_q;
	hsv_sector_t         sec_s2;
	logic [7:0]          val_s2;
	logic [15:0]         pn_s2;
	logic [HUE_BITS+7:0] cq_s2;
	logic [HUE_BITS+7:0] ct_s2;
	hsv_sector_t         sec_s4;
	logic [7:0]          val_s4;
	logic [7:0]          p_s4;
	logic [7:0]          q_s4;
	logic [7:0]          t_s4;
	rgb_pix_t            rgb_sel;
	rgb_pix_t            rgb_s5;

	// Advance a stage when it is empty or its contents move on
	assign en_s5     = !vld_q[4] || rgb_ready;
	assign stg_en.s4 = !vld_q[3] || en_s5;
	assign stg_en.s3 = !vld_q[2] || stg_en.s4;
	assign stg_en.s2 = !vld_q[1] || stg_en.s3;
	assign stg_en.s1 = !vld_q[0] || stg_en.s2;
	assign pix_ready = stg_en.s1;

	// Track valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg_en.s1) vld_q[0] <= pix_valid;
			if (stg_en.s2) vld_q[1] <= vld_q[0];
			if (stg_en.s3) vld_q[2] <= vld_q[1];
			if (stg_en.s4) vld_q[3] <= vld_q[2];
			if (en_s5)     vld_q[4] <= vld_q[3];
		end
	end

	hsv2rgb_front #(
		.HUE_BITS (HUE_BITS)
	) u_front (
		.clk    (clk),
		.stg_en (stg_en),
		.pix    (pix),
		.sec_s2 (sec_s2),
		.val_s2 (val_s2),
		.pn_s2  (pn_s2),
		.cq_s2  (cq_s2),
		.ct_s2  (ct_s2)
	);

	hsv2rgb_scale #(
		.HUE_BITS (HUE_BITS)
	) u_scale (
		.clk    (clk),
		.stg_en (stg_en),
		.sec_s2 (sec_s2),
		.val_s2 (val_s2),
		.pn_s2  (pn_s2),
		.cq_s2  (cq_s2),
		.ct_s2  (ct_s2),
		.sec_s4 (sec_s4),
		.val_s4 (val_s4),
		.p_s4   (p_s4),
		.q_s4   (q_s4),
		.t_s4   (t_s4)
	);

	// Route value and sector terms to the channels by hue sector
	always_comb begin
		case (sec_s4)
			SEC_RED_YEL: rgb_sel = '{red_out: val_s4, green_out: t_s4,   blue_out: p_s4};
			SEC_YEL_GRN: rgb_sel = '{red_out: q_s4,   green_out: val_s4, blue_out: p_s4};
			SEC_GRN_CYN: rgb_sel = '{red_out: p_s4,   green_out: val_s4, blue_out: t_s4};
			SEC_CYN_BLU: rgb_sel = '{red_out: p_s4,   green_out: q_s4,   blue_out: val_s4};
			SEC_BLU_MAG: rgb_sel = '{red_out: t_s4,   green_out: p_s4,   blue_out: val_s4};
			default:     rgb_sel = '{red_out: val_s4, green_out: p_s4,   blue_out: q_s4};
		endcase
	end

	// Stage 5: output register
	always_ff @(posedge clk) begin
		if (en_s5) begin
			rgb_s5 <= rgb_sel;
		end
	end

	assign rgb_valid = vld_q[4];
	assign rgb       = rgb_s5;

`ifndef SYNTH
	// Input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (&vld_q) && !rgb_ready)
		else $error("input stalled with a free stage");

	// A ready sink never backs up the input
	a_sink_drains: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_ready |-> pix_ready)
		else $error("input stalled while output drains");

	// An accepted request lands in the first stage
	a_req_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> vld_q[0])
		else $error("accepted request lost at stage 1");

	// Sector terms never exceed the value level
	a_terms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> (p_s4 <= val_s4) && (q_s4 <= val_s4) && (t_s4 <= val_s4))
		else $error("sector term above value level");
`endif

endmodule

@@ hw/rtl/hsv2rgb_front.sv @@
// Front stages of the converter: hue sector split, then the q/t coefficients
// and the p product. Depends on hsv2rgb_pkg.
module hsv2rgb_front
	import hsv2rgb_pkg::*;
#(
	parameter int HUE_BITS = HUE_BITS_DEF
) (
	input  logic                  clk,
	input  hsv_stg_en_t           stg_en,
	input  hsv_pix_t              pix,
	output hsv_sector_t           sec_s2,
	output logic [7:0]            val_s2,
	output logic [15:0]           pn_s2,
	output logic [HUE_BITS+7:0]   cq_s2,
	output logic [HUE_BITS+7:0]   ct_s2
);

	logic [HUE_BITS-1:0] hue;
	logic [HUE_BITS+2:0] hue6;
	hsv_sector_t         sec_s1;
	logic [HUE_BITS-1:0] fr_s1;
	logic [7:0]          sat_s1;
	logic [7:0]          val_s1;
	logic [HUE_BITS+7:0] fs;
	logic [7:0]          sat_inv;

	// Wrap hue to one turn and scale by six
	assign hue  = HUE_BITS'(pix.hue_frac);
	assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

	// Stage 1: hold sector, fraction and levels
	always_ff @(posedge clk) begin
		if (stg_en.s1) begin
			sec_s1 <= hsv_sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
			fr_s1  <= hue6[HUE_BITS-1:0];
			sat_s1 <= pix.sat_level;
			val_s1 <= pix.val_level;
		end
	end

	// Fraction times saturation feeds both q and t coefficients
	assign fs      = (HUE_BITS+8)'(fr_s1) * (HUE_BITS+8)'(sat_s1);
	assign sat_inv = LVL_MAX - sat_s1;

	// Stage 2: q = 255d - f*s, t = (255-s)d + f*s, p numerator v*(255-s)
	always_ff @(posedge clk) begin
		if (stg_en.s2) begin
			sec_s2 <= sec_s1;
			val_s2 <= val_s1;
			pn_s2  <= 16'(val_s1) * 16'(sat_inv);
			cq_s2  <= {LVL_MAX, {HUE_BITS{1'b0}}} - fs;
			ct_s2  <= {sat_inv, {HUE_BITS{1'b0}}} + fs;
		end
	end

endmodule

@@ hw/rtl/hsv2rgb_scale.sv @@
// Back stages of the converter: scale q/t coefficients by value, then
// divide all three sector terms by 255. Depends on hsv2rgb_pkg.
module hsv2rgb_scale
	import hsv2rgb_pkg::*;
#(
	parameter int HUE_BITS = HUE_BITS_DEF
) (
	input  logic                  clk,
	input  hsv_stg_en_t           stg_en,
	input  hsv_sector_t           sec_s2,
	input  logic [7:0]            val_s2,
	input  logic [15:0]           pn_s2,
	input  logic [HUE_BITS+7:0]   cq_s2,
	input  logic [HUE_BITS+7:0]   ct_s2,
	output hsv_sector_t           sec_s4,
	output logic [7:0]            val_s4,
	output logic [7:0]            p_s4,
	output logic [7:0]            q_s4,
	output logic [7:0]            t_s4
);

	logic [HUE_BITS+15:0] nq;
	logic [HUE_BITS+15:0] nt;
	hsv_sector_t          sec_s3;
	logic [7:0]           val_s3;
	logic [15:0]          pn_s3;
	logic [15:0]          mq_s3;
	logic [15:0]          mt_s3;

	// Value times coefficient; drop the hue fraction scale
	assign nq = (HUE_BITS+16)'(val_s2) * (HUE_BITS+16)'(cq_s2);
	assign nt = (HUE_BITS+16)'(val_s2) * (HUE_BITS+16)'(ct_s2);

	// Stage 3: hold the scaled numerators over 255
	always_ff @(posedge clk) begin
		if (stg_en.s3) begin
			sec_s3 <= sec_s2;
			val_s3 <= val_s2;
			pn_s3  <= pn_s2;
			mq_s3  <= nq[HUE_BITS+15:HUE_BITS];
			mt_s3  <= nt[HUE_BITS+15:HUE_BITS];
		end
	end

	// Stage 4: truncating divide by 255 of each term
	always_ff @(posedge clk) begin
		if (stg_en.s4) begin
			sec_s4 <= sec_s3;
			val_s4 <= val_s3;
			p_s4   <= div255(pn_s3);
			q_s4   <= div255(mq_s3);
			t_s4   <= div255(mt_s3);
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for hsv_to_rgb_converter_unit: directed and random HSV pixels,
// predicted RGB compared field by field. Depends on hsv2rgb_pkg and the converter RTL.
module testbench;
	import hsv2rgb_pkg::*;

	localparam int HUE_W        = HUE_BITS_DEF;
	localparam int RANDOM_PIX   = 950;
	localparam int QUIET_FROM   = 350;
	localparam int QUIET_TO     = 550;
	localparam int HOLDOFF_AT   = 700;
	localparam int HOLDOFF_LEN  = 80;
	localparam int STUCK_LIMIT  = 2000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      pix_valid = 1'b0;
	logic      pix_ready;
	hsv_pix_t  pix       = '0;
	logic      rgb_valid;
	logic      rgb_ready = 1'b0;
	rgb_pix_t  rgb;

	hsv_pix_t  pix_backlog[$];
	rgb_pix_t  rgb_due[$];
	logic      pix_took   = 1'b0;
	int        pix_sent   = 0;
	int        rgb_checked = 0;
	int        directed_cnt = 0;
	int        err_count  = 0;
	int        stuck_cycles = 0;
	int        holdoff_left = 0;
	bit        holdoff_done = 1'b0;

	hsv_to_rgb_converter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Six-sector HSV conversion, each component truncated from the exact value
	function automatic rgb_pix_t convert_pixel(hsv_pix_t px);
		logic [63:0] turn, h6, frac, den, s, v, p, q, t;
		hsv_sector_t sec;
		rgb_pix_t    c;
		turn = 64'd1 << HUE_W;
		h6   = 64'(px.hue_frac) * 64'd6;
		sec  = hsv_sector_t'(h6 >> HUE_W);
		frac = h6 & (turn - 64'd1);
		s    = 64'(px.sat_level);
		v    = 64'(px.val_level);
		den  = 64'd255 * turn;
		p    = v * (64'd255 - s) / 64'd255;
		q    = v * (den - frac * s) / den;
		t    = v * (den - (turn - frac) * s) / den;
		case (sec)
			SEC_RED_YEL: c = {v[7:0], t[7:0], p[7:0]};
			SEC_YEL_GRN: c = {q[7:0], v[7:0], p[7:0]};
			SEC_GRN_CYN: c = {p[7:0], v[7:0], t[7:0]};
			SEC_CYN_BLU: c = {p[7:0], q[7:0], v[7:0]};
			SEC_BLU_MAG: c = {t[7:0], p[7:0], v[7:0]};
			default:     c = {v[7:0], p[7:0], q[7:0]};
		endcase
		return c;
	endfunction

	task automatic queue_pix(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v);
		hsv_pix_t px;
		px.hue_frac  = h;
		px.sat_level = s;
		px.val_level = v;
		pix_backlog.push_back(px);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return LVL_MAX;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Drive requests at the falling edge; hold each until it is taken
	always @(negedge clk) begin
		bit quiet;
		quiet = (pix_sent >= QUIET_FROM) && (pix_sent < QUIET_TO);
		if (arst_n && (!pix_valid || pix_took)) begin
			if (pix_backlog.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
				pix       <= pix_backlog.pop_front();
				pix_valid <= 1'b1;
				pix_sent  <= pix_sent + 1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Drive result ready: random stalls, one long hold-off to back up the pipeline
	always @(negedge clk) begin
		bit quiet;
		quiet = (rgb_checked >= QUIET_FROM) && (rgb_checked < QUIET_TO);
		if (!holdoff_done && pix_sent >= HOLDOFF_AT) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_LEN;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			rgb_ready <= 1'b0;
		end else begin
			rgb_ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	// Sample both channels at the rising edge; predict on request, check on result
	always @(posedge clk) begin
		rgb_pix_t want;
		pix_took <= arst_n && pix_valid && pix_ready;
		if (arst_n) begin
			if (pix_valid && pix_ready)
				rgb_due.push_back(convert_pixel(pix));
			if (rgb_valid && rgb_ready) begin
				if (rgb_due.size() == 0) begin
					$error("unexpected result: r=%0d g=%0d b=%0d",
						rgb.red_out, rgb.green_out, rgb.blue_out);
					err_count++;
				end else begin
					want = rgb_due.pop_front();
					if (rgb.red_out !== want.red_out) begin
						$error("red_out: expected %0d, got %0d", want.red_out, rgb.red_out);
						err_count++;
					end
					if (rgb.green_out !== want.green_out) begin
						$error("green_out: expected %0d, got %0d",
							want.green_out, rgb.green_out);
						err_count++;
					end
					if (rgb.blue_out !== want.blue_out) begin
						$error("blue_out: expected %0d, got %0d",
							want.blue_out, rgb.blue_out);
						err_count++;
					end
				end
				rgb_checked++;
			end
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n && ((pix_valid && pix_ready) || (rgb_valid && rgb_ready)))
			stuck_cycles <= 0;
		else if (arst_n)
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
			$display("** hsv_to_rgb_converter_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int          k;
		logic [15:0] edge_hue;

		// Directed: hue wrap ends, both sides of every sector boundary, gray, black
		queue_pix(16'd0,     8'd255, 8'd255);
		queue_pix(16'hFFFF,  8'd255, 8'd255);
		queue_pix(16'd10922, 8'd255, 8'd255);
		queue_pix(16'd10923, 8'd255, 8'd255);
		queue_pix(16'd21845, 8'd255, 8'd255);
		queue_pix(16'd21846, 8'd255, 8'd255);
		queue_pix(16'd32767, 8'd255, 8'd255);
		queue_pix(16'd32768, 8'd255, 8'd255);
		queue_pix(16'd43690, 8'd255, 8'd255);
		queue_pix(16'd43691, 8'd255, 8'd255);
		queue_pix(16'd54613, 8'd255, 8'd255);
		queue_pix(16'd54614, 8'd255, 8'd255);
		queue_pix(16'd0,     8'd0,   8'd255);
		queue_pix(16'd40000, 8'd0,   8'd128);
		queue_pix(16'd30000, 8'd255, 8'd0);
		queue_pix(16'd12345, 8'd128, 8'd255);
		queue_pix(16'd50000, 8'd1,   8'd254);
		queue_pix(16'd5000,  8'd255, 8'd1);
		queue_pix(16'd60000, 8'd200, 8'd100);
		queue_pix(16'd20000, 8'd254, 8'd255);
		queue_pix(16'hAAAA,  8'h55,  8'hAA);
		queue_pix(16'h5555,  8'hAA,  8'h55);
		directed_cnt = pix_backlog.size();

		// Random: mostly uniform hue, some near sector edges, levels biased to extremes
		for (int i = 0; i < RANDOM_PIX; i++) begin
			if ($urandom_range(7) == 0) begin
				k = $urandom_range(5);
				edge_hue = 16'((k * 65536 + 5) / 6 + $urandom_range(4) - 2);
			end else begin
				edge_hue = 16'($urandom_range(16'hFFFF));
			end
			queue_pix(edge_hue, pick_level(), pick_level());
		end

		// Hold reset, then release at a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all requests taken, all results back, then a final idle wait
		while (pix_backlog.size() > 0 || pix_valid)
			@(posedge clk);
		while (rgb_due.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("%0d pixels sent (%0d directed), %0d results checked;", pix_sent,
			directed_cnt, rgb_checked);
		$display("output held off once for %0d cycles with input still offered", HOLDOFF_LEN);
		if (err_count == 0 && rgb_due.size() == 0) begin
			$display("** hsv_to_rgb_converter_unit: PASSED **");
		end else begin
			$display("** hsv_to_rgb_converter_unit: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_scale.sv
hw/rtl/hsv_to_rgb_converter_unit.sv
verif/testbench.sv
